/* hw/rtl/vfm_pkg.sv */
// Package for the voxel face mesher: payload structs, face and corner tables.
// No dependencies.
`default_nettype none
package vfm_pkg;

  localparam int unsigned VertexCountWidth = 32;
  localparam logic [15:0] UvScaleReset = 16'd4096;

  typedef struct packed {
    logic        chunk_start;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic        is_solid;
    logic [26:0] neighbour_opaque;
    logic [5:0]  culls_same;
    logic [47:0] tile_u_packed;
    logic [47:0] tile_v_packed;
  } voxel_t;

  typedef struct packed {
    logic [16:0] vertex_x;
    logic [16:0] vertex_y;
    logic [16:0] vertex_z;
    logic [2:0]  face_dir;
    logic [23:0] tex_u;
    logic [23:0] tex_v;
    logic [1:0]  ao_level;
    logic [8:0]  shade;
    logic [VertexCountWidth-1:0] vertex_index;
    logic        diagonal_flipped;
    logic        last;
  } vertex_t;

  // One exposed face, handed from front to back
  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [2:0]  face;
    logic [7:0]  ao;      // four 2-bit levels, vertex i at bits 2i
    logic        flip;
    logic [7:0]  tile_u;
    logic [7:0]  tile_v;
    logic        clear;   // reset counter before this face
    logic        last;    // final face of the voxel
  } face_t;

  // Corner offsets xyz (bit2=x, bit1=y, bit0=z)
  function automatic logic [2:0] corner_xyz(input logic [2:0] c);
    logic [2:0] r;
    begin
      r = 3'b000;
      unique case (c)
        3'd0: r = 3'b111;
        3'd1: r = 3'b011;
        3'd2: r = 3'b001;
        3'd3: r = 3'b101;
        3'd4: r = 3'b010;
        3'd5: r = 3'b110;
        3'd6: r = 3'b100;
        3'd7: r = 3'b000;
        default: r = 3'b000;
      endcase
      return r;
    end
  endfunction

  function automatic logic [2:0] face_corner(input logic [2:0] d, input logic [1:0] i);
    logic [11:0] row;
    begin
      row = 12'd0;
      unique case (d)
        3'd0: row = {3'd1, 3'd0, 3'd2, 3'd3};
        3'd1: row = {3'd0, 3'd5, 3'd3, 3'd6};
        3'd2: row = {3'd5, 3'd4, 3'd6, 3'd7};
        3'd3: row = {3'd4, 3'd1, 3'd7, 3'd2};
        3'd4: row = {3'd0, 3'd1, 3'd5, 3'd4};
        3'd5: row = {3'd6, 3'd7, 3'd3, 3'd2};
        default: row = 12'd0;
      endcase
      return row[3*i +: 3];
    end
  endfunction

  // Neighbourhood bit index of ring entry k of face d
  function automatic logic [4:0] ring_bit(input logic [2:0] d, input logic [2:0] k);
    logic [39:0] row;
    begin
      row = 40'd0;
      // entries listed k=7..0, each (dz+1)*9+(dy+1)*3+dx+1
      unique case (d)
        3'd0: row = {5'd23, 5'd20, 5'd19, 5'd18, 5'd21, 5'd24, 5'd25, 5'd26};
        3'd1: row = {5'd5, 5'd2, 5'd11, 5'd20, 5'd23, 5'd26, 5'd17, 5'd8};
        3'd2: row = {5'd3, 5'd0, 5'd1, 5'd2, 5'd5, 5'd8, 5'd7, 5'd6};
        3'd3: row = {5'd21, 5'd18, 5'd9, 5'd0, 5'd3, 5'd6, 5'd15, 5'd24};
        3'd4: row = {5'd15, 5'd6, 5'd7, 5'd8, 5'd17, 5'd26, 5'd25, 5'd24};
        3'd5: row = {5'd9, 5'd18, 5'd19, 5'd20, 5'd11, 5'd2, 5'd1, 5'd0};
        default: row = 40'd0;
      endcase
      return row[5*k +: 5];
    end
  endfunction

  function automatic logic [4:0] normal_bit(input logic [2:0] d);
    logic [4:0] r;
    begin
      r = 5'd13;
      unique case (d)
        3'd0: r = 5'd22;
        3'd1: r = 5'd14;
        3'd2: r = 5'd4;
        3'd3: r = 5'd12;
        3'd4: r = 5'd16;
        3'd5: r = 5'd10;
        default: r = 5'd13;
      endcase
      return r;
    end
  endfunction

  function automatic logic [8:0] shade_q8(input logic [1:0] a);
    logic [8:0] r;
    begin
      r = 9'd256;
      unique case (a)
        2'd0: r = 9'd38;
        2'd1: r = 9'd77;
        2'd2: r = 9'd154;
        2'd3: r = 9'd256;
        default: r = 9'd256;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/vfm_front.sv */
// Front: accepts voxels, walks exposed faces one a cycle while face_ready_i is high, computes AO and flip.
// Depends on vfm_pkg.
`default_nettype none
module vfm_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire vfm_pkg::voxel_t voxel_i,
  output logic                face_valid_o,
  input  wire logic           face_ready_i,
  output vfm_pkg::face_t      face_o
);
  import vfm_pkg::*;

  voxel_t     vox_q;
  logic       busy_q;
  logic [5:0] todo_q, todo_d;
  logic       clr_q, clr_d;
  logic       busy_d;
  logic [2:0] d;
  logic [5:0] pick;
  logic [5:0] exposed;
  logic [3:0] s1, s2, cc;
  logic [7:0] ao;
  logic [1:0] m03, m12;
  logic       stepped;

  // Exposed-face mask of an incoming voxel
  always_comb begin
    for (int f = 0; f < 6; f++) begin
      exposed[f] = voxel_i.is_solid & ~voxel_i.culls_same[f]
                   & ~voxel_i.neighbour_opaque[normal_bit(3'(f))];
    end
  end

  // Lowest pending face
  always_comb begin
    d = 3'd0;
    for (int f = 5; f >= 0; f--) begin
      if (todo_q[f]) d = 3'(f);
    end
    pick = 6'(1) << d;
  end

  // AO per vertex: ring picks (s1,corner,s2) = (7,6,5),(5,4,3),(1,0,7),(3,2,1)
  always_comb begin
    s1 = {vox_q.neighbour_opaque[ring_bit(d, 3'd3)], vox_q.neighbour_opaque[ring_bit(d, 3'd1)],
          vox_q.neighbour_opaque[ring_bit(d, 3'd5)], vox_q.neighbour_opaque[ring_bit(d, 3'd7)]};
    cc = {vox_q.neighbour_opaque[ring_bit(d, 3'd2)], vox_q.neighbour_opaque[ring_bit(d, 3'd0)],
          vox_q.neighbour_opaque[ring_bit(d, 3'd4)], vox_q.neighbour_opaque[ring_bit(d, 3'd6)]};
    s2 = {vox_q.neighbour_opaque[ring_bit(d, 3'd1)], vox_q.neighbour_opaque[ring_bit(d, 3'd7)],
          vox_q.neighbour_opaque[ring_bit(d, 3'd3)], vox_q.neighbour_opaque[ring_bit(d, 3'd5)]};
    for (int i = 0; i < 4; i++) begin
      if (s1[i] & s2[i]) ao[2*i +: 2] = 2'd0;
      else ao[2*i +: 2] = 2'd3 - (2'(s1[i]) + 2'(s2[i]) + 2'(cc[i]));
    end
    m03 = (ao[1:0] < ao[7:6]) ? ao[1:0] : ao[7:6];
    m12 = (ao[3:2] < ao[5:4]) ? ao[3:2] : ao[5:4];
  end

  assign face_valid_o = busy_q;
  assign stepped      = busy_q & face_ready_i;
  assign full         = busy_q & ~(stepped & ((todo_q & ~pick) == 6'd0));

  always_comb begin
    face_o.pos_x  = vox_q.pos_x;
    face_o.pos_y  = vox_q.pos_y;
    face_o.pos_z  = vox_q.pos_z;
    face_o.face   = d;
    face_o.ao     = ao;
    face_o.flip   = (m03 > m12);
    face_o.tile_u = vox_q.tile_u_packed[8*d +: 8];
    face_o.tile_v = vox_q.tile_v_packed[8*d +: 8];
    face_o.clear  = clr_q;
    face_o.last   = ((todo_q & ~pick) == 6'd0);
  end

  // Face walk control; a voxel with no faces but chunk_start leaves a pending clear
  logic take;
  logic pend_clr_q, pend_clr_d;
  assign take = push & ~full;
  always_comb begin
    todo_d = todo_q;
    busy_d = busy_q;
    clr_d  = clr_q;
    pend_clr_d = pend_clr_q;
    if (stepped) begin
      todo_d = todo_q & ~pick;
      busy_d = (todo_d != 6'd0);
      clr_d  = 1'b0;
    end
    if (take) begin
      if (exposed != 6'd0) begin
        todo_d = exposed;
        busy_d = 1'b1;
        clr_d  = voxel_i.chunk_start | pend_clr_q;
        pend_clr_d = 1'b0;
      end else if (voxel_i.chunk_start) begin
        pend_clr_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      todo_q <= '0;
      clr_q  <= 1'b0;
      pend_clr_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      todo_q <= todo_d;
      clr_q  <= clr_d;
      pend_clr_q <= pend_clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) vox_q <= voxel_i;
  end
endmodule
`default_nettype wire

/* hw/rtl/vfm_fifo.sv */
// Short face queue between front and back.
// Depends on vfm_pkg.
`default_nettype none
module vfm_fifo (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire vfm_pkg::face_t in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output vfm_pkg::face_t  out_o
);
  import vfm_pkg::*;

  face_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = mem_q[rp_q];
  assign wr = in_valid_i & in_ready_o;
  assign rd = out_valid_o & out_ready_i;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_i;
  end
endmodule
`default_nettype wire

/* hw/rtl/vfm_back.sv */
// Back: expands a face into four vertices, UV multiply, counter; output register.
// Depends on vfm_pkg.
`default_nettype none
module vfm_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [15:0]   uv_scale_i,
  input  wire logic          face_valid_i,
  output logic               face_ready_o,
  input  wire vfm_pkg::face_t face_i,
  output logic               empty,
  input  wire logic          pop,
  output vfm_pkg::vertex_t   vertex_o
);
  import vfm_pkg::*;

  logic [1:0] vi_q;
  logic [VertexCountWidth-1:0] cnt_q, base;
  logic       oval_q;
  vertex_t    out_q, v;
  logic       load;
  logic [2:0] cxyz;
  logic [8:0] tu, tv;
  logic [1:0] a;
  logic [23:0] pu, pv;

  assign load = face_valid_i & (~oval_q | pop);
  assign face_ready_o = load & (vi_q == 2'd3);
  assign empty = ~oval_q;
  assign vertex_o = out_q;

  // Vertex build; clear flag applies only to the first vertex of the face
  always_comb begin
    base = (face_i.clear && (vi_q == 2'd0)) ? '0 : cnt_q;
    cxyz = corner_xyz(face_corner(face_i.face, vi_q));
    tu = 9'(face_i.tile_u) + 9'(vi_q[0]);
    tv = 9'(face_i.tile_v) + 9'(vi_q[1]);
    pu = 24'(tu) * 24'(uv_scale_i);
    pv = 24'(tv) * 24'(uv_scale_i);
    a  = face_i.ao[2*vi_q +: 2];
    v.vertex_x = {face_i.pos_x[15], face_i.pos_x} + 17'(cxyz[2]);
    v.vertex_y = {face_i.pos_y[15], face_i.pos_y} + 17'(cxyz[1]);
    v.vertex_z = {face_i.pos_z[15], face_i.pos_z} + 17'(cxyz[0]);
    v.face_dir = face_i.face;
    v.tex_u = pu;
    v.tex_v = pv;
    v.ao_level = a;
    v.shade = shade_q8(a);
    v.vertex_index = base;
    v.diagonal_flipped = face_i.flip;
    v.last = face_i.last & (vi_q == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q <= 2'd0;
      cnt_q <= '0;
      oval_q <= 1'b0;
    end else begin
      if (load) begin
        vi_q <= vi_q + 2'd1;
        cnt_q <= base + 1'b1;
        oval_q <= 1'b1;
      end else if (pop) begin
        oval_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load) out_q <= v;
  end
endmodule
`default_nettype wire

/* hw/rtl/voxel_face_mesher_with_ao_top.sv */
// Top level of the voxel face mesher: front, face queue, back, uv_scale register.
// Depends on vfm_pkg, vfm_front, vfm_fifo, vfm_back.
//
//  channel  | ports                       | handshake
//  voxel in | push, full, voxel_i         | beat when push & !full
//  vertex   | empty, pop, vertex_o        | beat when pop & !empty
//  config   | cfg_we_i, cfg_wdata_i       | write when cfg_we_i
//
// Front emits one exposed face per cycle unless the queue is full; back emits one vertex
// per cycle while its output is popped, so a voxel gives 4 vertices per exposed face (up to 24).
// Vertex rate is bound by the back's single output register.
// Reset clears counter, queue and uv_scale (4096). Stalls on pop back up through queue.
`default_nettype none
module voxel_face_mesher_with_ao_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire vfm_pkg::voxel_t voxel_i,
  output logic              empty,
  input  wire logic         pop,
  output vfm_pkg::vertex_t  vertex_o,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i
);
  import vfm_pkg::*;

  logic [15:0] uv_scale_q;
  face_t f_face, b_face;
  logic f_valid, f_ready, b_valid, b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) uv_scale_q <= UvScaleReset;
    else if (cfg_we_i) uv_scale_q <= cfg_wdata_i;
  end

  vfm_front u_front (
    .clk_i, .rst_ni, .push, .full, .voxel_i,
    .face_valid_o(f_valid), .face_ready_i(f_ready), .face_o(f_face)
  );

  vfm_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_i(f_face),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_o(b_face)
  );

  vfm_back u_back (
    .clk_i, .rst_ni, .uv_scale_i(uv_scale_q),
    .face_valid_i(b_valid), .face_ready_o(b_ready), .face_i(b_face),
    .empty, .pop, .vertex_o
  );
endmodule
`default_nettype wire

/* hw/rtl/vfm_checker.sv */
// Port-level checks for the voxel face mesher, bound to the top level.
// Depends on vfm_pkg.
`default_nettype none
module vfm_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            empty,
  input wire logic            pop,
  input wire vfm_pkg::vertex_t vertex_o
);
  // Held vertex stays while not popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(vertex_o)) else $error("vertex changed");
  // Face id in range
  a_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> vertex_o.face_dir < 3'd6) else $error("bad face");
  // Shade follows AO level
  a_shade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> vertex_o.shade == vfm_pkg::shade_q8(vertex_o.ao_level)) else $error("shade");
endmodule

bind voxel_face_mesher_with_ao_top vfm_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .vertex_o
);
`default_nettype wire
